// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/lsbbp_pkg.sv -----
`default_nettype none
package lsbbp_pkg;
    localparam logic FUNC_PUT   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam int COUNT_W = 7;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 3;
    localparam int LEFT_W  = 4;
    localparam int BUF_W   = VALUE_W + BYTE_W;

    typedef struct packed {
        logic load_put;
        logic load_flush;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic put_emits;
        logic fill_nz;
        logic left_nz;
        logic last;
    } t_status;
endpackage
`default_nettype wire

// ----- rtl/lsbbp_datapath.sv -----
`default_nettype none
module lsbbp_datapath
    import lsbbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [COUNT_W-1:0] i_bit_count,
    input  wire logic [VALUE_W-1:0] i_value,
    output t_status                 o_st,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_last
);
    logic [BUF_W-1:0]   r_buf,  n_buf;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [FILL_W-1:0]  r_fill, n_fill;

    logic [COUNT_W-1:0] cnt_sat;
    logic [VALUE_W-1:0] mask;
    logic [BUF_W-1:0]   put_buf;
    logic [COUNT_W-1:0] total;

    always_comb begin
        cnt_sat = (i_bit_count > COUNT_W'(VALUE_W)) ? COUNT_W'(VALUE_W) : i_bit_count;
        // shift of 64 or more yields zero, so the mask becomes all ones
        mask    = ~({VALUE_W{1'b1}} << cnt_sat);
        put_buf = {{VALUE_W{1'b0}}, r_buf[BYTE_W-1:0]}
                | ({{BYTE_W{1'b0}}, i_value & mask} << r_fill);
        total   = COUNT_W'(r_fill) + cnt_sat;
    end

    always_comb begin
        n_buf  = r_buf;
        n_left = r_left;
        n_fill = r_fill;
        if (i_cmd.load_put) begin
            n_buf  = put_buf;
            n_left = total[COUNT_W-1:FILL_W];
            n_fill = total[FILL_W-1:0];
        end else if (i_cmd.load_flush) begin
            n_buf  = {{VALUE_W{1'b0}}, r_buf[BYTE_W-1:0]};
            n_left = LEFT_W'(1);
            n_fill = '0;
        end else if (i_cmd.shift) begin
            n_buf  = {{BYTE_W{1'b0}}, r_buf[BUF_W-1:BYTE_W]};
            n_left = r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_left <= '0;
            r_fill <= '0;
        end else begin
            r_buf  <= n_buf;
            r_left <= n_left;
            r_fill <= n_fill;
        end
    end

    always_comb begin
        o_st.put_emits = (total[COUNT_W-1:FILL_W] != '0);
        o_st.fill_nz   = (r_fill != '0);
        o_st.left_nz   = (r_left != '0);
        o_st.last      = (r_left == LEFT_W'(1));
        o_out_byte     = r_buf[BYTE_W-1:0];
        o_last         = o_st.last;
    end
endmodule
`default_nettype wire

// ----- rtl/lsbbp_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module lsbbp_ctrl
    import lsbbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_func,
    input  wire logic    i_out_stall,
    input  wire t_status i_st,
    output t_cmd         o_cmd,
    output logic         o_in_stall,
    output logic         o_out_valid
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state, n_state;
    logic in_acc;

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_EMIT);
        in_acc      = i_in_valid && !o_in_stall;
        o_cmd       = '0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_PUT) begin
                        o_cmd.load_put = 1'b1;
                        if (i_st.put_emits) n_state = S_EMIT;
                    end else if (i_st.fill_nz) begin
                        o_cmd.load_flush = 1'b1;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.shift = 1'b1;
                    if (i_st.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_CLK(a_emit_has_bytes, i_clk, i_rst_n, (r_state != S_EMIT) || i_st.left_nz, "emitting with no bytes left")
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, (r_state == S_EMIT) && !i_out_stall && i_st.last, r_state == S_IDLE, "last word did not end emission")
    `ASSERT_CLK(a_cmd_onehot, i_clk, i_rst_n, $onehot0({o_cmd.load_put, o_cmd.load_flush, o_cmd.shift}), "conflicting datapath commands")
endmodule
`default_nettype wire

// ----- rtl/lsb_first_bit_packer_top.sv -----
// The first word of an item is offered in the cycle after the item is accepted.
// A put completes from 0 to 8 bytes and a flush with pending bits emits its partial byte;
// an empty flush emits nothing. The byte shifter emits one word a cycle unless the output
// stalls, and takes the next item only after the last word of the current one has left.
// Reset (synchronous, active low) clears the partial byte, the fill count and the controller.
`default_nettype none
module lsb_first_bit_packer_top
    import lsbbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_func,
    input  wire logic [COUNT_W-1:0] i_bit_count,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_last
);
    // Command and status between the sequencer and the byte shifter.
    t_cmd    cmd;
    t_status st;

    // Controller: take an item when idle, then advance one word per unstalled cycle.
    lsbbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath: merge masked value bits above the partial byte into a 72-bit buffer,
    // hold the low byte on the output and drop it once taken.
    lsbbp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_bit_count (i_bit_count),
        .i_value     (i_value),
        .o_st        (st),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire
